// ----- hw/rtl/hufir_pkg.sv -----
// Shared constants, codes and types of the held-upsample complex FIR core.
package hufir_pkg;

   // Sizes of the tap store and history line
   localparam int TAPS      = 64;
   localparam int TAP_AW    = $clog2(TAPS);
   localparam int MAX_RATIO = 16;
   localparam int STEP_W    = (MAX_RATIO > 1) ? $clog2(MAX_RATIO) : 1;

   // Field widths
   localparam int ACTION_W  = 2;
   localparam int INDEX_W   = 6;
   localparam int COEF_W    = 18;
   localparam int SAMPLE_W  = 16;
   localparam int OUT_W     = 41;
   localparam int PROD_W    = COEF_W + SAMPLE_W;
   localparam int RATIO_W   = 5;
   localparam int NTAPS_W   = 7;

   // Register port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NTAPS = 2'd1;

   // Action codes
   localparam logic [ACTION_W-1:0] ACT_LOAD_TAP = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_PUSH     = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR    = 2'd2;

   // Control that travels with one history/tap pair into the MAC
   typedef struct packed {
      logic vld;
      logic first;
      logic last;
   } mac_ctl_type;

endpackage

// ----- hw/rtl/hufir_mac.sv -----
// Pipelined complex multiply-accumulate: product stage, then accumulate stage.
module hufir_mac
   import hufir_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  mac_ctl_type                in_ctl,
   input  logic signed [SAMPLE_W-1:0] hist_re,
   input  logic signed [SAMPLE_W-1:0] hist_im,
   input  logic signed [COEF_W-1:0]   tap_re,
   input  logic signed [COEF_W-1:0]   tap_im,
   output logic                       sum_vld,
   output logic signed [OUT_W-1:0]    sum_re,
   output logic signed [OUT_W-1:0]    sum_im
);

   mac_ctl_type               ctl_ff;
   logic signed [PROD_W-1:0]  pr_rr_ff, pr_ii_ff, pr_ri_ff, pr_ir_ff;
   logic signed [PROD_W-1:0]  pr_rr_in, pr_ii_in, pr_ri_in, pr_ir_in;
   logic signed [OUT_W-1:0]   rr_x, ii_x, ri_x, ir_x;
   logic signed [OUT_W-1:0]   base_re, base_im;
   logic signed [OUT_W-1:0]   acc_re_ff, acc_im_ff, acc_re_in, acc_im_in;
   logic                      sum_vld_ff;

   // Four partial products, full width
   assign pr_rr_in = PROD_W'(hist_re) * PROD_W'(tap_re);
   assign pr_ii_in = PROD_W'(hist_im) * PROD_W'(tap_im);
   assign pr_ri_in = PROD_W'(hist_re) * PROD_W'(tap_im);
   assign pr_ir_in = PROD_W'(hist_im) * PROD_W'(tap_re);

   always_ff @(posedge clock) begin
      pr_rr_ff <= pr_rr_in;
      pr_ii_ff <= pr_ii_in;
      pr_ri_ff <= pr_ri_in;
      pr_ir_ff <= pr_ir_in;
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= in_ctl;
      end
   end

   // Accumulate; first term of a sum restarts from zero
   assign rr_x    = OUT_W'(pr_rr_ff);
   assign ii_x    = OUT_W'(pr_ii_ff);
   assign ri_x    = OUT_W'(pr_ri_ff);
   assign ir_x    = OUT_W'(pr_ir_ff);
   assign base_re = ctl_ff.first ? '0 : acc_re_ff;
   assign base_im = ctl_ff.first ? '0 : acc_im_ff;
   assign acc_re_in = base_re + rr_x - ii_x;
   assign acc_im_in = base_im + ri_x + ir_x;

   always_ff @(posedge clock) begin
      if (ctl_ff.vld) begin
         acc_re_ff <= acc_re_in;
         acc_im_ff <= acc_im_in;
      end
      if (reset) begin
         sum_vld_ff <= 1'b0;
      end else begin
         sum_vld_ff <= ctl_ff.vld && ctl_ff.last;
      end
   end

   assign sum_vld = sum_vld_ff;
   assign sum_re  = acc_re_ff;
   assign sum_im  = acc_im_ff;

endmodule

// ----- hw/rtl/held_upsample_complex_fir_core.sv -----
// Top level of the held-upsample complex FIR core: sequencer, tap and history memories.
//
// Request channel (req_*): one word per action. Load tap writes one complex tap,
// clear zeroes the history line, push sample holds the sample for upsample_ratio
// fine steps and returns one rsp word per step; the last carries last_of_sample.
// Unknown actions are dropped. For a push, every fine step writes the sample into
// the history memory, then one shared complex MAC reads one history entry and one
// tap per cycle from the memories; the MAC pipeline then drains and the sum is
// handed to the output register.
// req_stall is high while a push is in work; one push is worked on at a time.
// Register port (csr_*): csr_ready is always high; write only while idle.
// Index 0 is upsample_ratio (reset 1), index 1 is taps_in_use (reset 64).
// Reset clears taps, history, head and registers at once through per-entry
// valid bits; no clearing pass is needed.
// When the receiver stalls, the output word holds and the sequencer waits with
// the next sum until the output register frees up.
module held_upsample_complex_fir_core
   import hufir_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [ACTION_W-1:0]        req_action,
   input  logic [INDEX_W-1:0]         req_tap_index,
   input  logic signed [COEF_W-1:0]   req_tap_re,
   input  logic signed [COEF_W-1:0]   req_tap_im,
   input  logic signed [SAMPLE_W-1:0] req_sample_re,
   input  logic signed [SAMPLE_W-1:0] req_sample_im,
   // response channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [OUT_W-1:0]    rsp_out_re,
   output logic signed [OUT_W-1:0]    rsp_out_im,
   output logic                       rsp_last_of_sample,
   // register port
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_READ,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   state_type                    state_ff;
   logic [RATIO_W-1:0]           ratio_ff, ratio_eff, ratio_run_ff;
   logic [NTAPS_W-1:0]           ntaps_ff, ntaps_eff, ntaps_run_ff;
   logic [TAP_AW-1:0]            head_ff, head_nx;
   logic [TAP_AW-1:0]            rd_pos_ff, rd_pos_nx;
   logic [TAP_AW-1:0]            tap_cnt_ff;
   logic [STEP_W-1:0]            step_ff;
   logic [2*SAMPLE_W-1:0]        samp_ff;
   logic                         req_acc, step_last, tap_last, out_free;
   logic signed [OUT_W-1:0]      res_re_ff, res_im_ff;
   logic signed [OUT_W-1:0]      rsp_re_ff, rsp_im_ff;
   logic                         rsp_valid_ff, rsp_last_ff;
   mac_ctl_type                  rd_ctl_ff;

   // Memories and their valid bits
   logic [2*SAMPLE_W-1:0]        hist_mem [TAPS];
   logic [2*COEF_W-1:0]          tap_mem  [TAPS];
   logic [TAPS-1:0]              hist_vld_ff, tap_vld_ff;
   logic [2*SAMPLE_W-1:0]        hist_q_ff;
   logic [2*COEF_W-1:0]          tap_q_ff;
   logic                         hist_vq_ff, tap_vq_ff;
   logic                         hist_we, tap_we, hist_clr;

   // MAC hookup
   logic signed [SAMPLE_W-1:0]   mac_hist_re, mac_hist_im;
   logic signed [COEF_W-1:0]     mac_tap_re, mac_tap_im;
   logic                         sum_vld;
   logic signed [OUT_W-1:0]      sum_re, sum_im;

   // Register port
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff <= RATIO_W'(1);
         ntaps_ff <= NTAPS_W'(TAPS);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_RATIO: ratio_ff <= csr_data[RATIO_W-1:0];
            CSR_NTAPS: ntaps_ff <= csr_data[NTAPS_W-1:0];
            default:   ;
         endcase
      end
   end

   // Clamp registers to legal ranges
   always_comb begin
      if (ratio_ff == '0) begin
         ratio_eff = RATIO_W'(1);
      end else if (ratio_ff > RATIO_W'(MAX_RATIO)) begin
         ratio_eff = RATIO_W'(MAX_RATIO);
      end else begin
         ratio_eff = ratio_ff;
      end
      if (ntaps_ff > NTAPS_W'(TAPS)) begin
         ntaps_eff = NTAPS_W'(TAPS);
      end else begin
         ntaps_eff = ntaps_ff;
      end
   end

   // Handshake and sequencing terms
   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign head_nx   = (head_ff == TAP_AW'(TAPS - 1)) ? '0 : head_ff + 1'b1;
   assign rd_pos_nx = (rd_pos_ff == '0) ? TAP_AW'(TAPS - 1) : rd_pos_ff - 1'b1;
   assign step_last = (RATIO_W'(step_ff) + 1'b1) == ratio_run_ff;
   assign tap_last  = (NTAPS_W'(tap_cnt_ff) + 1'b1) == ntaps_run_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign hist_we  = (state_ff == ST_WRITE);
   assign tap_we   = req_acc && (req_action == ACT_LOAD_TAP);
   assign hist_clr = req_acc && (req_action == ACT_CLEAR);

   // History memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[head_nx] <= samp_ff;
      end
      hist_q_ff <= hist_mem[rd_pos_ff];
   end

   // Tap memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (tap_we) begin
         tap_mem[req_tap_index[TAP_AW-1:0]] <= {req_tap_re, req_tap_im};
      end
      tap_q_ff <= tap_mem[tap_cnt_ff];
   end

   // Valid bits: an entry never written reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         hist_vld_ff <= '0;
         tap_vld_ff  <= '0;
         hist_vq_ff  <= 1'b0;
         tap_vq_ff   <= 1'b0;
      end else begin
         hist_vq_ff <= hist_vld_ff[rd_pos_ff];
         tap_vq_ff  <= tap_vld_ff[tap_cnt_ff];
         if (hist_clr) begin
            hist_vld_ff <= '0;
         end else if (hist_we) begin
            hist_vld_ff[head_nx] <= 1'b1;
         end
         if (tap_we) begin
            tap_vld_ff[req_tap_index[TAP_AW-1:0]] <= 1'b1;
         end
      end
   end

   // Sequencer with result and output registers
   always_ff @(posedge clock) begin
      rd_ctl_ff <= '0;
      if (sum_vld) begin
         res_re_ff <= sum_re;
         res_im_ff <= sum_im;
      end
      if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               case (req_action)
                  ACT_PUSH: begin
                     samp_ff      <= {req_sample_re, req_sample_im};
                     ratio_run_ff <= ratio_eff;
                     ntaps_run_ff <= ntaps_eff;
                     step_ff      <= '0;
                     state_ff     <= ST_WRITE;
                  end
                  ACT_CLEAR: head_ff <= '0;
                  default:   ;
               endcase
            end
         end
         ST_WRITE: begin
            // newest entry goes in, then walk back from it
            head_ff    <= head_nx;
            rd_pos_ff  <= head_nx;
            tap_cnt_ff <= '0;
            if (ntaps_run_ff == '0) begin
               res_re_ff <= '0;
               res_im_ff <= '0;
               state_ff  <= ST_EMIT;
            end else begin
               state_ff <= ST_READ;
            end
         end
         ST_READ: begin
            rd_ctl_ff.vld   <= 1'b1;
            rd_ctl_ff.first <= (tap_cnt_ff == '0);
            rd_ctl_ff.last  <= tap_last;
            rd_pos_ff       <= rd_pos_nx;
            tap_cnt_ff      <= tap_cnt_ff + 1'b1;
            if (tap_last) begin
               state_ff <= ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (sum_vld) begin
               state_ff <= ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_ff <= 1'b1;
               rsp_re_ff    <= res_re_ff;
               rsp_im_ff    <= res_im_ff;
               rsp_last_ff  <= step_last;
               step_ff      <= step_ff + 1'b1;
               state_ff     <= step_last ? ST_IDLE : ST_WRITE;
            end
         end
         default: state_ff <= ST_IDLE;
      endcase
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         rd_pos_ff    <= '0;
         tap_cnt_ff   <= '0;
         step_ff      <= '0;
         ratio_run_ff <= RATIO_W'(1);
         ntaps_run_ff <= NTAPS_W'(TAPS);
         rd_ctl_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end
   end

   // Unwritten entries count as zero
   assign mac_hist_re = hist_vq_ff ? hist_q_ff[2*SAMPLE_W-1:SAMPLE_W] : '0;
   assign mac_hist_im = hist_vq_ff ? hist_q_ff[SAMPLE_W-1:0]          : '0;
   assign mac_tap_re  = tap_vq_ff  ? tap_q_ff[2*COEF_W-1:COEF_W]      : '0;
   assign mac_tap_im  = tap_vq_ff  ? tap_q_ff[COEF_W-1:0]             : '0;

   hufir_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .in_ctl  (rd_ctl_ff),
      .hist_re (mac_hist_re),
      .hist_im (mac_hist_im),
      .tap_re  (mac_tap_re),
      .tap_im  (mac_tap_im),
      .sum_vld (sum_vld),
      .sum_re  (sum_re),
      .sum_im  (sum_im)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_re         = rsp_re_ff;
   assign rsp_out_im         = rsp_im_ff;
   assign rsp_last_of_sample = rsp_last_ff;

   // A finished sum only shows up while the sequencer waits for it
   a_sum_in_drain: assert property (@(posedge clock) disable iff (reset)
      sum_vld |-> (state_ff == ST_DRAIN))
      else $error("MAC sum outside drain");

   // The tap walk never runs past the taps in use
   a_tap_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (NTAPS_W'(tap_cnt_ff) < ntaps_run_ff))
      else $error("tap counter past taps in use");

   // Fine-step counter stays below the ratio while a push is in work
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (RATIO_W'(step_ff) < ratio_run_ff))
      else $error("fine step past ratio");

   // The last word of a sample returns the sequencer to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EMIT) && out_free && step_last) |=> (state_ff == ST_IDLE))
      else $error("sequencer busy after last fine step");

endmodule

// ----- bench/held_upsample_complex_fir_core_test.sv -----
// Self-checking bench for the held-upsample complex FIR core with a fine-step output ledger.
module held_upsample_complex_fir_core_test;
   import hufir_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int LONG_HOLD      = 500;
   localparam int SETTLE_CYCLES  = 16;
   localparam int TAIL_CYCLES    = 40;

   // codes the package leaves unnamed
   localparam logic [ACTION_W-1:0]  ACT_UNKNOWN   = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_TWO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_THR = 2'd3;

   localparam logic signed [COEF_W-1:0]   COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
   localparam logic signed [COEF_W-1:0]   COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
   localparam logic signed [SAMPLE_W-1:0] SAMP_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] SAMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   typedef struct {
      logic signed [OUT_W-1:0] re;
      logic signed [OUT_W-1:0] im;
      logic                    last;
   } fine_out_t;

   // Tracks taps, history and registers; queues the fine-step outputs each push causes
   class fine_step_ledger;
      logic signed [COEF_W-1:0]   tap_re [TAPS];
      logic signed [COEF_W-1:0]   tap_im [TAPS];
      logic signed [SAMPLE_W-1:0] hist_re [TAPS];
      logic signed [SAMPLE_W-1:0] hist_im [TAPS];
      int unsigned                head;
      logic [RATIO_W-1:0]         ratio_reg;
      logic [NTAPS_W-1:0]         ntaps_reg;
      fine_out_t                  pending [$];
      int unsigned                errors;

      function new();
         foreach (tap_re[i]) begin
            tap_re[i] = '0;
            tap_im[i] = '0;
         end
         clear_history();
         ratio_reg = 5'd1;
         ntaps_reg = 7'd64;
         errors    = 0;
      endfunction

      function void clear_history();
         foreach (hist_re[i]) begin
            hist_re[i] = '0;
            hist_im[i] = '0;
         end
         head = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_RATIO: ratio_reg = data[RATIO_W-1:0];
            CSR_NTAPS: ntaps_reg = data[NTAPS_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned active_taps();
         return (ntaps_reg > TAPS) ? TAPS : ntaps_reg;
      endfunction

      // one push: hold the sample for the ratio, one complex FIR sum per fine step
      function void hold_sample(logic signed [SAMPLE_W-1:0] s_re,
                                logic signed [SAMPLE_W-1:0] s_im);
         int unsigned steps;
         int unsigned n;
         int unsigned pos;
         longint      acc_re;
         longint      acc_im;
         fine_out_t   w;
         steps = (ratio_reg == 0) ? 1 : ((ratio_reg > MAX_RATIO) ? MAX_RATIO : ratio_reg);
         n     = active_taps();
         for (int unsigned s = 0; s < steps; s++) begin
            head = (head + 1 >= TAPS) ? 0 : head + 1;
            hist_re[head] = s_re;
            hist_im[head] = s_im;
            pos    = head;
            acc_re = 0;
            acc_im = 0;
            for (int unsigned t = 0; t < n; t++) begin
               acc_re += longint'(hist_re[pos]) * longint'(tap_re[t])
                       - longint'(hist_im[pos]) * longint'(tap_im[t]);
               acc_im += longint'(hist_re[pos]) * longint'(tap_im[t])
                       + longint'(hist_im[pos]) * longint'(tap_re[t]);
               pos = (pos == 0) ? TAPS - 1 : pos - 1;
            end
            w.re   = acc_re[OUT_W-1:0];
            w.im   = acc_im[OUT_W-1:0];
            w.last = (s + 1 == steps);
            pending.push_back(w);
         end
      endfunction

      function void apply_request(logic [ACTION_W-1:0] action, logic [INDEX_W-1:0] idx,
                                  logic signed [COEF_W-1:0] c_re,
                                  logic signed [COEF_W-1:0] c_im,
                                  logic signed [SAMPLE_W-1:0] s_re,
                                  logic signed [SAMPLE_W-1:0] s_im);
         case (action)
            ACT_LOAD_TAP: begin
               if (idx < TAPS) begin
                  tap_re[idx] = c_re;
                  tap_im[idx] = c_im;
               end
            end
            ACT_CLEAR: clear_history();
            ACT_PUSH:  hold_sample(s_re, s_im);
            default: ;
         endcase
      endfunction

      function void compare_output(logic signed [OUT_W-1:0] re, logic signed [OUT_W-1:0] im,
                                   logic last);
         fine_out_t w;
         if (pending.size() == 0) begin
            $error("unexpected output word: out_re %0d out_im %0d last_of_sample %0d",
                   re, im, last);
            errors++;
            return;
         end
         w = pending.pop_front();
         if (re !== w.re) begin
            $error("out_re: expected %0d, got %0d", w.re, re);
            errors++;
         end
         if (im !== w.im) begin
            $error("out_im: expected %0d, got %0d", w.im, im);
            errors++;
         end
         if (last !== w.last) begin
            $error("last_of_sample: expected %0d, got %0d", w.last, last);
            errors++;
         end
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [ACTION_W-1:0]        req_action;
   logic [INDEX_W-1:0]         req_tap_index;
   logic signed [COEF_W-1:0]   req_tap_re;
   logic signed [COEF_W-1:0]   req_tap_im;
   logic signed [SAMPLE_W-1:0] req_sample_re;
   logic signed [SAMPLE_W-1:0] req_sample_im;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic signed [OUT_W-1:0]    rsp_out_re;
   logic signed [OUT_W-1:0]    rsp_out_im;
   logic                       rsp_last_of_sample;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [CSR_DATA_W-1:0]      csr_data;

   fine_step_ledger fir_ledger = new();
   int unsigned     send_idle_pct = 24;
   int unsigned     recv_idle_pct = 73;
   bit              hold_request  = 1'b0;
   int unsigned     quiet_cycles  = 0;

   held_upsample_complex_fir_core DUT (.*);

   always #5 clock = ~clock;

   // check accepted output words; watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_valid && !rsp_stall)
            fir_ledger.compare_output(rsp_out_re, rsp_out_im, rsp_last_of_sample);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall) || (csr_valid && csr_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("held_upsample_complex_fir_core: mismatch");
            $finish;
         end
      end
   end

   // receiver: random stall, plus one long hold-off on request
   initial begin
      int unsigned hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else begin
            rsp_stall = ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   function automatic logic signed [COEF_W-1:0] any_coef();
      case ($urandom_range(7))
         0: return COEF_MAX;
         1: return COEF_MIN;
         default: return COEF_W'($urandom);
      endcase
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] any_sample();
      case ($urandom_range(7))
         0: return SAMP_MAX;
         1: return SAMP_MIN;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // offer one request word, holding it until accepted
   task automatic send_word(logic [ACTION_W-1:0] action, logic [INDEX_W-1:0] idx,
                            logic signed [COEF_W-1:0] c_re, logic signed [COEF_W-1:0] c_im,
                            logic signed [SAMPLE_W-1:0] s_re,
                            logic signed [SAMPLE_W-1:0] s_im);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_action    = action;
      req_tap_index = idx;
      req_tap_re    = c_re;
      req_tap_im    = c_im;
      req_sample_re = s_re;
      req_sample_im = s_im;
      do @(posedge clock); while (req_stall);
      fir_ledger.apply_request(action, idx, c_re, c_im, s_re, s_im);
   endtask

   task automatic drain_outputs();
      @(negedge clock);
      req_valid = 1'b0;
      while (fir_ledger.pending.size() != 0) @(posedge clock);
   endtask

   // register write; every caller first lets the core go quiet
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      do @(posedge clock); while (!csr_ready);
      fir_ledger.write_register(idx, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic settle_idle();
      drain_outputs();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic directed_words();
      send_word(ACT_PUSH,     6'd0,  '0, '0, SAMP_MAX, SAMP_MAX);
      send_word(ACT_LOAD_TAP, 6'd0,  COEF_MAX, COEF_MIN, '0, '0);
      send_word(ACT_LOAD_TAP, 6'd63, COEF_MIN, COEF_MAX, '0, '0);
      send_word(ACT_LOAD_TAP, 6'd1,  18'sd1, -18'sd1, '0, '0);
      send_word(ACT_PUSH,     6'd0,  '0, '0, SAMP_MAX, SAMP_MIN);
      send_word(ACT_PUSH,     6'd0,  '0, '0, SAMP_MIN, SAMP_MAX);
      send_word(ACT_PUSH,     6'd0,  '0, '0, SAMP_MIN, SAMP_MIN);
      send_word(ACT_PUSH,     6'd0,  '0, '0, '0, '0);
      send_word(ACT_UNKNOWN,  6'd5,  COEF_MAX, COEF_MAX, SAMP_MAX, SAMP_MAX);
      send_word(ACT_CLEAR,    6'd63, COEF_MIN, COEF_MIN, SAMP_MIN, SAMP_MIN);
      send_word(ACT_PUSH,     6'd0,  '0, '0, SAMP_MAX, SAMP_MAX);
      send_word(ACT_LOAD_TAP, 6'd63, COEF_MIN, COEF_MIN, '0, '0);
      send_word(ACT_PUSH,     6'd0,  '0, '0, -16'sd1, 16'sd1);
      send_word(ACT_CLEAR,    6'd0,  '0, '0, '0, '0);
      send_word(ACT_PUSH,     6'd0,  '0, '0, 16'sd1, '0);
      send_word(ACT_LOAD_TAP, 6'd32, COEF_MAX, COEF_MAX, '0, '0);
      send_word(ACT_UNKNOWN,  6'd0,  '0, '0, '0, '0);
      send_word(ACT_PUSH,     6'd0,  '0, '0, SAMP_MIN, SAMP_MIN);
   endtask

   // mostly pushes and tap loads, some clears, a little noise
   task automatic random_words(int unsigned count);
      int unsigned         done;
      int unsigned         roll;
      logic [ACTION_W-1:0] action;
      logic [INDEX_W-1:0]  idx;
      done = 0;
      while (done < count) begin
         roll = $urandom_range(99);
         if (roll < 60)      action = ACT_PUSH;
         else if (roll < 85) action = ACT_LOAD_TAP;
         else if (roll < 93) action = ACT_CLEAR;
         else                action = ACT_UNKNOWN;
         if ($urandom_range(1) && fir_ledger.active_taps() > 0)
            idx = INDEX_W'($urandom_range(fir_ledger.active_taps() - 1));
         else
            idx = INDEX_W'($urandom_range(TAPS - 1));
         send_word(action, idx, any_coef(), any_coef(), any_sample(), any_sample());
         if (action != ACT_UNKNOWN) begin
            done++;
            if (done % 25 == 0)
               drain_outputs();
         end
      end
   endtask

   task automatic run_phase(logic [CSR_DATA_W-1:0] ratio_data, logic [CSR_DATA_W-1:0] ntaps_data,
                            int unsigned count, int unsigned send_pct, int unsigned recv_pct,
                            bit long_hold);
      settle_idle();
      write_csr(CSR_RATIO, ratio_data);
      write_csr(CSR_NTAPS, ntaps_data);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      if (long_hold)
         hold_request = 1'b1;
      random_words(count);
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_action    = ACT_LOAD_TAP;
      req_tap_index = '0;
      req_tap_re    = '0;
      req_tap_im    = '0;
      req_sample_re = '0;
      req_sample_im = '0;
      csr_valid     = 1'b0;
      csr_index     = CSR_RATIO;
      csr_data      = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset register values first, then sweeps including the saturating extremes
      directed_words();
      run_phase(8'h00, 8'h00, 8, 24, 73, 1'b0);
      settle_idle();
      write_csr(CSR_SPARE_TWO, 8'hFF);
      write_csr(CSR_SPARE_THR, 8'h00);
      run_phase(8'h03, 8'h05, 40, 24, 73, 1'b0);
      run_phase(8'h10, 8'h40, 10, 24, 73, 1'b0);
      run_phase(8'hFF, 8'hFF, 6, 73, 24, 1'b0);
      run_phase(8'h01, 8'h01, 40, 73, 24, 1'b1);
      run_phase(8'h02, 8'h0C, 50, 73, 24, 1'b0);
      run_phase(8'h11, 8'h41, 4, 73, 24, 1'b0);
      run_phase({1'($urandom_range(1)), 2'b00, 5'($urandom_range(1, 4))},
                {1'b0, 7'($urandom_range(1, 20))}, 60, 0, 0, 1'b1);
      run_phase(8'h05, 8'h3F, 30, 0, 0, 1'b0);
      run_phase(8'h01, 8'h40, 40, 0, 0, 1'b0);

      drain_outputs();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fir_ledger.errors == 0 && fir_ledger.pending.size() == 0)
         $display("held_upsample_complex_fir_core: match");
      else
         $display("held_upsample_complex_fir_core: mismatch");
      $finish;
   end

endmodule
